[src/sude_pkg.sv]
package sude_pkg;

   localparam int RX_LIMIT    = 16;
   localparam int WIN_BYTES   = 8;
   localparam int CNT_W       = $clog2(RX_LIMIT + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  CRC_POLY      = 8'h07;
   localparam logic [7:0]  REPLY_ADDR    = 8'hFF;
   localparam logic [7:0]  NODE_RESET    = 8'h00;
   localparam logic [7:0]  SYNC_RESET    = 8'h05;
   localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
   localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_RX    = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_TX   = 2'd0,
      KIND_DONE = 2'd1,
      KIND_FAIL = 2'd2
   } out_kind_type;

   typedef enum logic [1:0] {
      JOB_WRITE = 2'd0,
      JOB_READ  = 2'd1,
      JOB_DONE  = 2'd2,
      JOB_FAIL  = 2'd3
   } job_kind_type;

   typedef enum logic [1:0] {
      REG_NODE    = 2'd0,
      REG_SYNC    = 2'd1,
      REG_TIMEOUT = 2'd2
   } reg_index_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   sync;
      logic [7:0]   node;
      logic [6:0]   reg_addr;
      logic [31:0]  value;
   } job_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[7] ^ data[k];
         c  = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

[src/sude_queue.sv]
module sude_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sude_pkg::job_type push_job,
   input  logic             pop,
   output sude_pkg::job_type head_job,
   output logic             head_valid,
   output logic             full
);
   import sude_pkg::*;

   job_type           mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
`endif

endmodule

[src/sude_front.sv]
module sude_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        command,
   input  logic [6:0]        reg_addr,
   input  logic [31:0]       write_value,
   input  logic [7:0]        rx_byte,
   input  logic [7:0]        node_address,
   input  logic [7:0]        sync_byte,
   input  logic [15:0]       timeout_ticks,
   output logic              push,
   output sude_pkg::job_type job
);
   import sude_pkg::*;

   logic              pend_ff, pend_in;
   logic [6:0]        exp_ff, exp_in;
   logic [55:0]       win_ff, win_in;
   logic [7:0]        part_ff [7];
   logic [7:0]        part_in [7];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [15:0]       timer_ff, timer_in;
   logic [CNT_W-1:0]  cnt_next;
   logic [15:0]       timer_next;
   logic              match;
   logic              shift;

   assign cnt_next   = cnt_ff + 1'b1;
   assign timer_next = (timer_ff == TIMER_MAX) ? timer_ff : timer_ff + 1'b1;
   assign match      = (cnt_next >= CNT_W'(WIN_BYTES))
                       && (win_ff[55:48] == sync_byte)
                       && (win_ff[47:40] == REPLY_ADDR)
                       && (win_ff[39:32] == {1'b0, exp_ff})
                       && (part_ff[0] == rx_byte);

   // part_ff[j] is the CRC over window bytes j..6, oldest first
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         part_in[j] = shift ? crc8_byte(part_ff[j+1], rx_byte) : part_ff[j];
      end
      part_in[6] = shift ? crc8_byte(8'h00, rx_byte) : part_ff[6];
   end

   always_comb begin
      pend_in       = pend_ff;
      exp_in        = exp_ff;
      cnt_in        = cnt_ff;
      timer_in      = timer_ff;
      shift         = 1'b0;
      push          = 1'b0;
      job.kind      = JOB_FAIL;
      job.sync      = sync_byte;
      job.node      = node_address;
      job.reg_addr  = reg_addr;
      job.value     = write_value;
      if (accept) begin
         unique case (cmd_type'(command))
            CMD_WRITE: begin
               pend_in  = 1'b0;
               cnt_in   = '0;
               timer_in = '0;
               push     = 1'b1;
               job.kind = JOB_WRITE;
            end
            CMD_READ: begin
               pend_in  = 1'b1;
               exp_in   = reg_addr;
               cnt_in   = '0;
               timer_in = '0;
               push     = 1'b1;
               job.kind = JOB_READ;
            end
            CMD_RX: begin
               if (pend_ff) begin
                  if (match) begin
                     pend_in   = 1'b0;
                     cnt_in    = '0;
                     timer_in  = '0;
                     push      = 1'b1;
                     job.kind  = JOB_DONE;
                     job.value = win_ff[31:0];
                  end else if (cnt_next >= CNT_W'(RX_LIMIT)) begin
                     pend_in  = 1'b0;
                     cnt_in   = '0;
                     timer_in = '0;
                     push     = 1'b1;
                     job.kind = JOB_FAIL;
                  end else begin
                     cnt_in = cnt_next;
                     shift  = 1'b1;
                  end
               end
            end
            CMD_TICK: begin
               if (pend_ff) begin
                  if (timer_next >= timeout_ticks) begin
                     pend_in  = 1'b0;
                     cnt_in   = '0;
                     timer_in = '0;
                     push     = 1'b1;
                     job.kind = JOB_FAIL;
                  end else begin
                     timer_in = timer_next;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign win_in = shift ? {win_ff[47:0], rx_byte} : win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         exp_ff   <= '0;
         cnt_ff   <= '0;
         timer_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         exp_ff   <= exp_in;
         cnt_ff   <= cnt_in;
         timer_ff <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      part_ff <= part_in;
   end

`ifndef NO_ASSERTIONS
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !pend_ff |-> (cnt_ff == '0 && timer_ff == '0))
      else $error("idle scanner holds count or timer");
   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(RX_LIMIT))
      else $error("receive count passed limit");
   a_read_arms: assert property (@(posedge clock) disable iff (reset)
      (accept && command == CMD_READ) |=> pend_ff)
      else $error("read request did not arm scanner");
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && accept && (command == CMD_RX || command == CMD_TICK)) ##1 !pend_ff
      |-> $past(push))
      else $error("read ended without a result");
`endif

endmodule

[src/sude_back.sv]
module sude_back (
   input  logic              clock,
   input  logic              reset,
   input  sude_pkg::job_type head_job,
   input  logic              head_valid,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last,
   output logic [31:0]       rsp_read_value
);
   import sude_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  tx_ff, tx_in;
   logic        last_ff, last_in;
   logic [31:0] value_ff, value_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  crc_ff, crc_in;
   logic        load;
   logic        is_frame;
   logic [2:0]  last_idx;
   logic        beat_last;
   logic [7:0]  frame_byte;

   assign load      = !valid_ff || !rsp_stall;
   assign is_frame  = (head_job.kind == JOB_WRITE) || (head_job.kind == JOB_READ);
   assign last_idx  = (head_job.kind == JOB_WRITE) ? 3'd7 : 3'd3;
   assign beat_last = !is_frame || (idx_ff == last_idx);
   assign pop       = load && head_valid && beat_last;

   always_comb begin
      frame_byte = crc_ff;
      case (idx_ff)
         3'd0: frame_byte = head_job.sync;
         3'd1: frame_byte = head_job.node;
         3'd2: frame_byte = {(head_job.kind == JOB_WRITE), head_job.reg_addr};
         3'd3: frame_byte = (head_job.kind == JOB_WRITE) ? head_job.value[31:24] : crc_ff;
         3'd4: frame_byte = head_job.value[23:16];
         3'd5: frame_byte = head_job.value[15:8];
         3'd6: frame_byte = head_job.value[7:0];
         default: frame_byte = crc_ff;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      tx_in    = tx_ff;
      last_in  = last_ff;
      value_in = value_ff;
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (is_frame) begin
               kind_in  = KIND_TX;
               tx_in    = frame_byte;
               last_in  = beat_last;
               value_in = '0;
               idx_in   = beat_last ? 3'd0 : idx_ff + 1'b1;
               crc_in   = crc8_byte((idx_ff == 3'd0) ? 8'h00 : crc_ff, frame_byte);
            end else begin
               kind_in  = (head_job.kind == JOB_DONE) ? KIND_DONE : KIND_FAIL;
               tx_in    = '0;
               last_in  = 1'b1;
               value_in = (head_job.kind == JOB_DONE) ? head_job.value : '0;
               idx_in   = 3'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      tx_ff    <= tx_in;
      last_ff  <= last_in;
      value_ff <= value_in;
      crc_ff   <= crc_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_tx_byte    = tx_ff;
   assign rsp_last       = last_ff;
   assign rsp_read_value = value_ff;

`ifndef NO_ASSERTIONS
   a_idx_frame: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 3'd0) |-> (head_valid && is_frame && idx_ff <= last_idx))
      else $error("beat index outside a frame");
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("job retired without a last beat");
   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != KIND_TX) |-> (last_ff && tx_ff == '0))
      else $error("read result beat malformed");
`endif

endmodule

[src/stepper_uart_datagram_engine.sv]
// A request's first beat or read result goes through the job queue, then the output register.
// Throughput: one item accepted per cycle while the four-entry job queue has room; the
// back end sends one beat per cycle while rsp_stall is low; write frames are 8 beats, reads 4.
// Receive bytes and ticks that end no read queue nothing; they are taken every cycle unless full.
// Reset (synchronous): registers return to node 0, sync 0x05, timeout 10000; any read is
// dropped and the queue and output register are emptied.
module stepper_uart_datagram_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [6:0]  req_reg_addr,
   input  logic [31:0] req_write_value,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic [31:0] rsp_read_value,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import sude_pkg::*;

   logic [7:0]  node_ff, node_in;
   logic [7:0]  sync_ff, sync_in;
   logic [15:0] timeout_ff, timeout_in;
   logic        cfg_write;
   logic        accept;
   logic        push;
   logic        pop;
   logic        full;
   logic        head_valid;
   job_type     push_job;
   job_type     head_job;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      node_in    = node_ff;
      sync_in    = sync_ff;
      timeout_in = timeout_ff;
      if (cfg_write) begin
         unique case (reg_index_type'(paddr[3:2]))
            REG_NODE:    node_in    = pwdata[7:0];
            REG_SYNC:    sync_in    = pwdata[7:0];
            REG_TIMEOUT: timeout_in = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[3:2]))
         REG_NODE:    prdata = {24'h0, node_ff};
         REG_SYNC:    prdata = {24'h0, sync_ff};
         REG_TIMEOUT: prdata = {16'h0, timeout_ff};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff    <= NODE_RESET;
         sync_ff    <= SYNC_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         node_ff    <= node_in;
         sync_ff    <= sync_in;
         timeout_ff <= timeout_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   sude_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .command       (req_command),
      .reg_addr      (req_reg_addr),
      .write_value   (req_write_value),
      .rx_byte       (req_rx_byte),
      .node_address  (node_ff),
      .sync_byte     (sync_ff),
      .timeout_ticks (timeout_ff),
      .push          (push),
      .job           (push_job)
   );

   sude_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .head_valid (head_valid),
      .full       (full)
   );

   sude_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_job       (head_job),
      .head_valid     (head_valid),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .rsp_read_value (rsp_read_value)
   );

endmodule

[tb/sv/stepper_uart_datagram_engine_test.sv]
module stepper_uart_datagram_engine_test;
   import sude_pkg::*;

   typedef struct {
      out_kind_type kind;
      logic [7:0]   tx_byte;
      logic         last;
      logic [31:0]  read_value;
   } rsp_beat_type;

   typedef enum {
      REPLY_GOOD,
      REPLY_BAD_CRC,
      REPLY_WRONG_REG,
      REPLY_HIGH_REG,
      REPLY_WRONG_SYNC
   } reply_flavor_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command     = CMD_TICK;
   logic [6:0]  req_reg_addr    = '0;
   logic [31:0] req_write_value = '0;
   logic [7:0]  req_rx_byte     = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;
   logic [31:0] rsp_read_value;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [3:0]  paddr           = '0;
   logic [31:0] pwdata          = '0;
   logic [31:0] prdata;
   logic        pready;

   // datagram engine state mirrored by the predictor
   logic [7:0]  eng_node;
   logic [7:0]  eng_sync;
   logic [15:0] eng_timeout;
   logic        eng_read_pending;
   logic [6:0]  eng_expected_reg;
   logic [55:0] eng_window;
   int          eng_rx_count;
   logic [15:0] eng_wait_timer;

   rsp_beat_type expected_beats[$];
   rsp_beat_type head_beat;
   logic        calm = 1'b0;
   int          mismatch_count = 0;
   int          beats_checked = 0;
   int          active_items = 0;
   int          requests_sent = 0;
   int          reads_done = 0;
   int          reads_failed = 0;

   stepper_uart_datagram_engine dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 10);
   end

   initial begin
      #2400000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [6:0] rand_reg();
      return 7'($urandom);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] datagram_crc(input logic [7:0] bytes [8], input int n);
      logic [7:0] c;
      c = 8'h00;
      for (int i = 0; i < n; i++) begin
         for (int b = 0; b < 8; b++) begin
            if (c[7] ^ bytes[i][b]) begin
               c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
               c = {c[6:0], 1'b0};
            end
         end
      end
      return c;
   endfunction

   function automatic void expect_beat(out_kind_type k, logic [7:0] tx, logic l,
                                       logic [31:0] v);
      rsp_beat_type b;
      b.kind       = k;
      b.tx_byte    = tx;
      b.last       = l;
      b.read_value = v;
      expected_beats.push_back(b);
   endfunction

   function automatic void drop_read();
      eng_read_pending = 1'b0;
      eng_window       = '0;
      eng_rx_count     = 0;
      eng_wait_timer   = '0;
   endfunction

   function automatic void step_datagram_engine(cmd_type cmd, logic [6:0] reg_a,
                                                logic [31:0] wval, logic [7:0] rxb);
      logic [7:0] f [8];
      case (cmd)
         CMD_WRITE: begin
            drop_read();
            f[0] = eng_sync;
            f[1] = eng_node;
            f[2] = {1'b1, reg_a};
            f[3] = wval[31:24];
            f[4] = wval[23:16];
            f[5] = wval[15:8];
            f[6] = wval[7:0];
            f[7] = datagram_crc(f, 7);
            for (int i = 0; i < 8; i++) expect_beat(KIND_TX, f[i], i == 7, '0);
            requests_sent++;
         end
         CMD_READ: begin
            drop_read();
            f[0] = eng_sync;
            f[1] = eng_node;
            f[2] = {1'b0, reg_a};
            for (int i = 3; i < 8; i++) f[i] = '0;
            f[3] = datagram_crc(f, 3);
            for (int i = 0; i < 4; i++) expect_beat(KIND_TX, f[i], i == 3, '0);
            eng_read_pending = 1'b1;
            eng_expected_reg = reg_a;
            requests_sent++;
         end
         CMD_RX: begin
            if (eng_read_pending) begin
               for (int i = 0; i < 7; i++) f[i] = eng_window[8*(6-i) +: 8];
               f[7] = rxb;
               eng_window = {eng_window[47:0], rxb};
               eng_rx_count++;
               if (eng_rx_count >= 8 && f[0] == eng_sync && f[1] == REPLY_ADDR &&
                   f[2] == {1'b0, eng_expected_reg} && datagram_crc(f, 7) == f[7]) begin
                  drop_read();
                  expect_beat(KIND_DONE, '0, 1'b1, {f[3], f[4], f[5], f[6]});
                  reads_done++;
               end else if (eng_rx_count >= RX_LIMIT) begin
                  drop_read();
                  expect_beat(KIND_FAIL, '0, 1'b1, '0);
                  reads_failed++;
               end
            end
         end
         default: begin
            if (eng_read_pending) begin
               if (eng_wait_timer != TIMER_MAX) eng_wait_timer++;
               if (eng_wait_timer >= eng_timeout) begin
                  drop_read();
                  expect_beat(KIND_FAIL, '0, 1'b1, '0);
                  reads_failed++;
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: kind %0d tx_byte %02h", rsp_kind, rsp_tx_byte);
            mismatch_count++;
         end else begin
            head_beat = expected_beats.pop_front();
            if (rsp_kind !== head_beat.kind) begin
               $error("kind: expected %0d, got %0d", head_beat.kind, rsp_kind);
               mismatch_count++;
            end
            if (rsp_tx_byte !== head_beat.tx_byte) begin
               $error("tx_byte: expected %02h, got %02h", head_beat.tx_byte, rsp_tx_byte);
               mismatch_count++;
            end
            if (rsp_last !== head_beat.last) begin
               $error("last: expected %0d, got %0d", head_beat.last, rsp_last);
               mismatch_count++;
            end
            if (rsp_read_value !== head_beat.read_value) begin
               $error("read_value: expected %08h, got %08h", head_beat.read_value,
                      rsp_read_value);
               mismatch_count++;
            end
         end
      end
   end

   task automatic push_command(cmd_type cmd, logic [6:0] reg_a, logic [31:0] wval,
                               logic [7:0] rxb);
      if (!calm) begin
         while ($urandom_range(99) < 10) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_reg_addr    <= reg_a;
      req_write_value <= wval;
      req_rx_byte     <= rxb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      active_items++;
      step_datagram_engine(cmd, reg_a, wval, rxb);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_beats.size() != 0);
   endtask

   task automatic write_csr(reg_index_type idx, logic [31:0] val);
      logic [31:0] mask;
      mask = (idx == REG_TIMEOUT) ? 32'h0000_FFFF : 32'h0000_00FF;
      drain_results();
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (val & mask)) begin
         $error("csr %0d readback: expected %08h, got %08h", idx, val & mask, prdata);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_NODE:    eng_node    = val[7:0];
         REG_SYNC:    eng_sync    = val[7:0];
         REG_TIMEOUT: eng_timeout = val[15:0];
         default: ;
      endcase
   endtask

   task automatic send_reply(logic [6:0] reg_a, logic [31:0] val, reply_flavor_type flavor,
                             int nbytes, int tick_pct);
      logic [7:0] f [8];
      f[0] = eng_sync;
      f[1] = REPLY_ADDR;
      f[2] = {1'b0, reg_a};
      f[3] = val[31:24];
      f[4] = val[23:16];
      f[5] = val[15:8];
      f[6] = val[7:0];
      case (flavor)
         REPLY_WRONG_REG:  f[2] = {1'b0, reg_a ^ (7'h01 << $urandom_range(6))};
         REPLY_HIGH_REG:   f[2][7] = 1'b1;
         REPLY_WRONG_SYNC: f[0] = ~eng_sync;
         default: ;
      endcase
      f[7] = datagram_crc(f, 7);
      if (flavor == REPLY_BAD_CRC) f[7] = f[7] ^ (8'h01 << $urandom_range(7));
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(99) < tick_pct) begin
            push_command(CMD_TICK, rand_reg(), $urandom, rand_byte());
         end
         push_command(CMD_RX, rand_reg(), $urandom, f[i]);
      end
   endtask

   task automatic test_write_frames;
      write_csr(REG_NODE, 32'h0000_00A5);
      write_csr(REG_SYNC, 32'h0000_0005);
      write_csr(REG_TIMEOUT, 32'd10000);
      push_command(CMD_WRITE, 7'h00, 32'h0000_0000, 8'h00);
      push_command(CMD_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
   endtask

   task automatic test_idle_input;
      push_command(CMD_RX, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
      push_command(CMD_TICK, 7'h00, 32'h0000_0000, 8'h00);
   endtask

   task automatic test_read_reply;
      push_command(CMD_READ, 7'h22, $urandom, rand_byte());
      send_reply(7'h22, 32'h8000_0001, REPLY_GOOD, 8, 0);
   endtask

   task automatic test_reply_rejects;
      push_command(CMD_READ, 7'h10, $urandom, rand_byte());
      send_reply(7'h10, $urandom, REPLY_HIGH_REG, 8, 0);
      // a new request drops the pending read without a failure beat
      push_command(CMD_WRITE, 7'h33, $urandom, rand_byte());
   endtask

   task automatic test_rx_limit;
      push_command(CMD_READ, 7'h01, $urandom, rand_byte());
      repeat (RX_LIMIT) push_command(CMD_RX, rand_reg(), $urandom, rand_byte());
   endtask

   task automatic test_short_window;
      logic [7:0] f [8];
      logic [31:0] v;
      write_csr(REG_NODE, 32'h0000_00FF);
      write_csr(REG_SYNC, 32'h0000_0000);
      v = $urandom;
      push_command(CMD_READ, 7'h45, $urandom, rand_byte());
      // zeroed window supplies the sync byte; only seven beats arrive, so no match
      f[0] = 8'h00;
      f[1] = REPLY_ADDR;
      f[2] = 8'h45;
      f[3] = v[31:24];
      f[4] = v[23:16];
      f[5] = v[15:8];
      f[6] = v[7:0];
      f[7] = datagram_crc(f, 7);
      for (int i = 1; i < 8; i++) push_command(CMD_RX, rand_reg(), $urandom, f[i]);
      push_command(CMD_READ, 7'h00, $urandom, rand_byte());
   endtask

   task automatic test_timeouts;
      write_csr(REG_TIMEOUT, 32'd0);
      push_command(CMD_READ, 7'h05, $urandom, rand_byte());
      push_command(CMD_TICK, rand_reg(), $urandom, rand_byte());
      write_csr(REG_TIMEOUT, 32'd1);
      push_command(CMD_READ, 7'h06, $urandom, rand_byte());
      push_command(CMD_TICK, rand_reg(), $urandom, rand_byte());
      write_csr(REG_TIMEOUT, 32'd3);
      push_command(CMD_READ, 7'h07, $urandom, rand_byte());
      push_command(CMD_TICK, rand_reg(), $urandom, rand_byte());
      push_command(CMD_RX, rand_reg(), $urandom, rand_byte());
      push_command(CMD_TICK, rand_reg(), $urandom, rand_byte());
      push_command(CMD_TICK, rand_reg(), $urandom, rand_byte());
   endtask

   task automatic test_random_traffic;
      int          pick;
      int          first_item;
      logic [6:0]  reg_a;
      int          flavor_pick;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               write_csr(REG_NODE, $urandom_range(255));
               write_csr(REG_SYNC, $urandom_range(255));
               write_csr(REG_TIMEOUT, $urandom_range(40, 4));
            end
            1: begin
               write_csr(REG_NODE, 32'h0000_00FF);
               write_csr(REG_SYNC, 32'h0000_0000);
               write_csr(REG_TIMEOUT, 32'd1);
            end
            2: begin
               write_csr(REG_NODE, 32'h0000_0000);
               write_csr(REG_SYNC, 32'h0000_00FF);
               write_csr(REG_TIMEOUT, 32'd65535);
            end
            default: begin
               write_csr(REG_NODE, $urandom_range(255));
               write_csr(REG_SYNC, $urandom_range(255));
               write_csr(REG_TIMEOUT, $urandom_range(24, 8));
            end
         endcase
         calm <= (p == 1);
         first_item = active_items;
         while (active_items - first_item < 85) begin
            pick = $urandom_range(99);
            if (pick < 5) drain_results();
            if (pick < 20) begin
               push_command(CMD_WRITE, rand_reg(), $urandom, rand_byte());
            end else if (pick < 75) begin
               reg_a = rand_reg();
               push_command(CMD_READ, reg_a, $urandom, rand_byte());
               repeat ($urandom_range(3)) push_command(CMD_RX, rand_reg(), $urandom, rand_byte());
               flavor_pick = $urandom_range(99);
               if (flavor_pick < 60) begin
                  send_reply(reg_a, $urandom, REPLY_GOOD, 8, 5);
               end else if (flavor_pick < 72) begin
                  send_reply(reg_a, $urandom, REPLY_BAD_CRC, 8, 5);
               end else if (flavor_pick < 80) begin
                  send_reply(reg_a, $urandom, REPLY_WRONG_REG, 8, 5);
               end else if (flavor_pick < 87) begin
                  send_reply(reg_a, $urandom, REPLY_HIGH_REG, 8, 5);
               end else if (flavor_pick < 93) begin
                  send_reply(reg_a, $urandom, REPLY_WRONG_SYNC, 8, 5);
               end else begin
                  send_reply(reg_a, $urandom, REPLY_GOOD, $urandom_range(7, 1), 5);
               end
            end else if (pick < 88) begin
               repeat ($urandom_range(6, 1)) begin
                  push_command(cmd_type'($urandom_range(CMD_RX, CMD_TICK)), rand_reg(),
                               $urandom, rand_byte());
               end
            end else begin
               push_command(CMD_READ, rand_reg(), $urandom, rand_byte());
               repeat ($urandom_range(RX_LIMIT + 2, RX_LIMIT - 2)) begin
                  push_command(CMD_RX, rand_reg(), $urandom, rand_byte());
               end
            end
         end
         calm <= 1'b0;
      end
   endtask

   initial begin
      eng_node    = NODE_RESET;
      eng_sync    = SYNC_RESET;
      eng_timeout = TIMEOUT_RESET;
      eng_expected_reg = '0;
      drop_read();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_write_frames();
      test_idle_input();
      test_read_reply();
      test_reply_rejects();
      test_rx_limit();
      test_short_window();
      test_timeouts();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      $display("covered %0d items, %0d request frames, %0d beats checked",
               active_items, requests_sent, beats_checked);
      $display("reads completed %0d, reads failed %0d, %0d mismatches",
               reads_done, reads_failed, mismatch_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
src/sude_pkg.sv
src/sude_queue.sv
src/sude_front.sv
src/sude_back.sv
src/stepper_uart_datagram_engine.sv
tb/sv/stepper_uart_datagram_engine_test.sv
